@@ hdl/iwseq_pkg.sv @@
package iwseq_pkg;

  // payload buffer geometry
  localparam int BUF_DEPTH = 256;
  localparam int BUF_AW    = $clog2(BUF_DEPTH);
  localparam int LEN_W     = $clog2(BUF_DEPTH + 1);

  localparam logic [7:0] RETRY_RESET = 8'd10;

  // request types
  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_START  = 2'd1;
  localparam logic [1:0] REQ_STATUS = 2'd2;

  // bus engine status codes
  localparam logic [7:0] ST_MASK      = 8'hF8;
  localparam logic [7:0] ST_START     = 8'h08;
  localparam logic [7:0] ST_RSTART    = 8'h10;
  localparam logic [7:0] ST_SLA_ACK   = 8'h18;
  localparam logic [7:0] ST_SLA_NACK  = 8'h20;
  localparam logic [7:0] ST_DATA_ACK  = 8'h28;
  localparam logic [7:0] ST_DATA_NACK = 8'h30;
  localparam logic [7:0] ST_ARB_LOST  = 8'h38;

  // error codes
  localparam logic [2:0] ERR_OK    = 3'd0;
  localparam logic [2:0] ERR_ADDR  = 3'd1;
  localparam logic [2:0] ERR_DATA  = 3'd2;
  localparam logic [2:0] ERR_ARB   = 3'd3;
  localparam logic [2:0] ERR_UNEXP = 3'd4;
  localparam logic [2:0] ERR_BUSY  = 3'd5;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] byte_index;
    logic [7:0] byte_value;
    logic [6:0] target_address;
    logic [7:0] payload_length;
    logic [7:0] bus_status;
  } item_t;

  // result of one step; payload byte comes from the buffer when from_buf is set
  typedef struct packed {
    logic       issue_start;
    logic       issue_stop;
    logic       send_valid;
    logic       from_buf;
    logic [7:0] addr_byte;
    logic       done_res;
    logic [2:0] error_code;
  } res_t;

  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [BUF_AW-1:0] addr;
    logic [7:0]        wr_data;
  } mem_req_t;

endpackage

@@ hdl/iwseq_buf.sv @@
module iwseq_buf
  import iwseq_pkg::*;
(
  input  logic       clk,
  input  mem_req_t   req,
  output logic [7:0] rd_data
);

  logic [7:0] mem [BUF_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.addr];
    end
  end

endmodule

@@ hdl/iwseq_ctrl.sv @@
module iwseq_ctrl
  import iwseq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  item_t      item,
  input  logic [7:0] retry_limit,
  output res_t       res,
  output mem_req_t   mem_req
);

  logic             busy;
  logic             busy_next;
  logic [LEN_W-1:0] send_pos;
  logic [LEN_W-1:0] send_pos_next;
  logic [LEN_W-1:0] active_len;
  logic [LEN_W-1:0] active_len_next;
  logic [6:0]       active_tgt;
  logic [6:0]       active_tgt_next;
  logic [7:0]       retry_cnt;
  logic [7:0]       retry_cnt_next;

  logic [7:0]       st;
  logic [LEN_W-1:0] len_in;
  logic [LEN_W-1:0] ack_pos;
  logic             exhausted;
  logic [2:0]       fail_err;

  always_comb begin
    st        = item.bus_status & ST_MASK;
    len_in    = LEN_W'(item.payload_length);
    if (len_in > LEN_W'(BUF_DEPTH)) begin
      len_in = LEN_W'(BUF_DEPTH);
    end
    ack_pos   = (send_pos < active_len) ? send_pos + 1'b1 : send_pos;
    exhausted = retry_cnt > retry_limit;
    fail_err  = (st == ST_SLA_NACK) ? ERR_ADDR : (st == ST_ARB_LOST) ? ERR_ARB : ERR_DATA;

    busy_next       = busy;
    send_pos_next   = send_pos;
    active_len_next = active_len;
    active_tgt_next = active_tgt;
    retry_cnt_next  = retry_cnt;
    res             = '0;
    mem_req         = '0;
    mem_req.wr_data = item.byte_value;
    mem_req.addr    = send_pos[BUF_AW-1:0];

    case (item.req_type)
      REQ_LOAD: begin
        mem_req.addr  = item.byte_index[BUF_AW-1:0];
        mem_req.wr_en = step && ({1'b0, item.byte_index} < 9'(BUF_DEPTH));
      end
      REQ_START: begin
        if (busy) begin
          res.error_code = ERR_BUSY;
        end else begin
          busy_next       = 1'b1;
          retry_cnt_next  = '0;
          active_tgt_next = item.target_address;
          active_len_next = len_in;
          send_pos_next   = '0;
          res.issue_start = 1'b1;
        end
      end
      REQ_STATUS: begin
        if (busy) begin
          case (st)
            ST_START, ST_RSTART: begin
              res.send_valid = 1'b1;
              res.addr_byte  = {active_tgt, 1'b0};
            end
            ST_SLA_ACK, ST_DATA_ACK, ST_SLA_NACK, ST_ARB_LOST, ST_DATA_NACK: begin
              // failures first check the retry budget
              if ((st == ST_SLA_NACK || st == ST_ARB_LOST || st == ST_DATA_NACK)
                  && exhausted) begin
                busy_next      = 1'b0;
                res.issue_stop = 1'b1;
                res.done_res   = 1'b1;
                res.error_code = fail_err;
              end else begin
                if (st == ST_SLA_NACK || st == ST_ARB_LOST || st == ST_DATA_NACK) begin
                  if (retry_cnt != 8'hFF) begin
                    retry_cnt_next = retry_cnt + 1'b1;
                  end
                end
                if (st == ST_SLA_NACK || st == ST_ARB_LOST) begin
                  res.issue_start = 1'b1;
                end else begin
                  if (st == ST_DATA_ACK) begin
                    send_pos_next = ack_pos;
                  end
                  // send the byte at the (possibly advanced) position or finish
                  if (send_pos_next >= active_len) begin
                    busy_next      = 1'b0;
                    res.issue_stop = 1'b1;
                    res.done_res   = 1'b1;
                    res.error_code = ERR_OK;
                  end else begin
                    res.send_valid = 1'b1;
                    res.from_buf   = 1'b1;
                    mem_req.addr   = send_pos_next[BUF_AW-1:0];
                    mem_req.rd_en  = step;
                  end
                end
              end
            end
            default: begin
              busy_next      = 1'b0;
              res.done_res   = 1'b1;
              res.error_code = ERR_UNEXP;
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      send_pos   <= '0;
      active_len <= '0;
      active_tgt <= '0;
      retry_cnt  <= '0;
    end else if (step) begin
      busy       <= busy_next;
      send_pos   <= send_pos_next;
      active_len <= active_len_next;
      active_tgt <= active_tgt_next;
      retry_cnt  <= retry_cnt_next;
    end
  end

endmodule

@@ hdl/i2c_master_write_sequencer.sv @@
// each result beat is presented from the result register, fed by the input register
// throughput: one request beat per cycle, stalls only through out_ready backpressure
// rate set by the input register -> decode -> result register path with the
// buffer read landing in the result stage
// reset (rst, synchronous): idle, no transfer, retry limit 10, buffer contents undefined
module i2c_master_write_sequencer
  import iwseq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  // request channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] req_type,
  input  logic [7:0] byte_index,
  input  logic [7:0] byte_value,
  input  logic [6:0] target_address,
  input  logic [7:0] payload_length,
  input  logic [7:0] bus_status,
  // retry limit register
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  // result channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic       issue_start,
  output logic       issue_stop,
  output logic       send_valid,
  output logic [7:0] tx_byte,
  output logic       done_res,
  output logic [2:0] error_code
);

  // input stage
  logic     in_full;
  item_t    item;
  // result stage
  res_t     res;
  res_t     res_q;
  mem_req_t mem_req;
  logic [7:0] buf_rd_data;
  logic [7:0] retry_limit;
  logic       step;

  // the decoded beat moves into the result stage when that stage is free or draining
  assign step     = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= '{req_type, byte_index, byte_value, target_address,
                payload_length, bus_status};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      retry_limit <= RETRY_RESET;
    end else if (cfg_wr_en) begin
      retry_limit <= cfg_wr_data;
    end
  end

  // transfer state and per-beat decode
  iwseq_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .item        (item),
    .retry_limit (retry_limit),
    .res         (res),
    .mem_req     (mem_req)
  );

  // payload buffer; read data is registered alongside the result stage
  iwseq_buf u_buf (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (buf_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_q <= res;
    end
  end

  // buffer data only changes when a new payload send enters the result stage
  assign issue_start = res_q.issue_start;
  assign issue_stop  = res_q.issue_stop;
  assign send_valid  = res_q.send_valid;
  assign tx_byte     = res_q.from_buf ? buf_rd_data : res_q.addr_byte;
  assign done_res    = res_q.done_res;
  assign error_code  = res_q.error_code;

endmodule

@@ bench/tb_i2c_master_write_sequencer.sv @@
module tb_i2c_master_write_sequencer;
  import iwseq_pkg::*;

  // watchdog, far above the slowest legal run (about 1500 beats)
  localparam int CYCLE_LIMIT  = 200000;
  // extra settling once every expected result has come back
  localparam int DRAIN_CYCLES = 6;
  // request type the block must ignore
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // one result beat, as the result channel carries it
  typedef struct packed {
    logic       issue_start;
    logic       issue_stop;
    logic       send_valid;
    logic [7:0] tx_byte;
    logic       done_res;
    logic [2:0] error_code;
  } bus_action_t;

  logic       clk            = 1'b0;
  logic       rst            = 1'b1;
  logic       in_valid       = 1'b0;
  logic       in_ready;
  logic [1:0] req_type       = REQ_LOAD;
  logic [7:0] byte_index     = 8'd0;
  logic [7:0] byte_value     = 8'd0;
  logic [6:0] target_address = 7'd0;
  logic [7:0] payload_length = 8'd0;
  logic [7:0] bus_status     = 8'd0;
  logic       cfg_wr_en      = 1'b0;
  logic [7:0] cfg_wr_data    = 8'd0;
  logic       out_valid;
  logic       out_ready      = 1'b0;
  logic       issue_start;
  logic       issue_stop;
  logic       send_valid;
  logic [7:0] tx_byte;
  logic       done_res;
  logic [2:0] error_code;

  i2c_master_write_sequencer u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .req_type       (req_type),
    .byte_index     (byte_index),
    .byte_value     (byte_value),
    .target_address (target_address),
    .payload_length (payload_length),
    .bus_status     (bus_status),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .issue_start    (issue_start),
    .issue_stop     (issue_stop),
    .send_valid     (send_valid),
    .tx_byte        (tx_byte),
    .done_res       (done_res),
    .error_code     (error_code)
  );

  // sequencer state as the bench sees it
  logic [7:0]       payload_mem [BUF_DEPTH];
  logic [7:0]       send_pos   = 8'd0;
  logic [LEN_W-1:0] act_len    = '0;
  logic [6:0]       act_tgt    = 7'd0;
  logic [7:0]       retry_cnt  = 8'd0;
  logic             xfer_busy  = 1'b0;
  logic [7:0]       retry_lim  = RETRY_RESET;

  // expected result beats, oldest first
  bus_action_t pending_actions [$];

  int  err_count   = 0;
  int  beat_no     = 0;
  int  cycle_count = 0;
  int  stall_left  = 0;
  // random idling on the request side and on the result side
  logic sender_gaps = 1'b1;
  logic sink_stalls = 1'b1;

  initial begin
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycle_count,
               pending_actions.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side backpressure: random bursts of stalled cycles
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (sink_stalls && $urandom_range(0, 7) == 0) begin
      out_ready <= 1'b0;
      stall_left = $urandom_range(0, 3);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("beat %0d %s got %0h want %0h", beat_no, name, got, want));
  endtask

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // transfer ends: block goes idle
  function automatic void finish_xfer(inout bus_action_t a, input logic [2:0] err,
                                      input logic stop);
    xfer_busy    = 1'b0;
    a.issue_stop = stop;
    a.done_res   = 1'b1;
    a.error_code = err;
  endfunction

  // next payload byte, or stop and done once the length is reached
  function automatic void send_or_finish(inout bus_action_t a);
    if (LEN_W'(send_pos) >= act_len) begin
      finish_xfer(a, ERR_OK, 1'b1);
    end else begin
      a.send_valid = 1'b1;
      a.tx_byte    = payload_mem[send_pos];
    end
  endfunction

  // count one failure; returns 1 when retries ran out and the transfer was stopped
  function automatic logic retries_exhausted(inout bus_action_t a, input logic [2:0] err);
    if (retry_cnt > retry_lim) begin
      finish_xfer(a, err, 1'b1);
      return 1'b1;
    end
    if (retry_cnt != 8'hFF)
      retry_cnt++;
    return 1'b0;
  endfunction

  // apply one accepted request beat to the bench state, return the result it causes
  function automatic bus_action_t step_sequencer(input item_t it);
    bus_action_t a;
    logic [7:0]  st;
    a  = '0;
    st = it.bus_status & ST_MASK;
    if (it.req_type == REQ_LOAD) begin
      // every 8-bit index is inside the buffer
      payload_mem[it.byte_index] = it.byte_value;
    end else if (it.req_type == REQ_START) begin
      if (xfer_busy) begin
        a.error_code = ERR_BUSY;
      end else begin
        xfer_busy     = 1'b1;
        retry_cnt     = 8'd0;
        act_tgt       = it.target_address;
        // an 8-bit length never exceeds the buffer depth
        act_len       = LEN_W'(it.payload_length);
        send_pos      = 8'd0;
        a.issue_start = 1'b1;
      end
    end else if (it.req_type == REQ_STATUS && xfer_busy) begin
      case (st)
        ST_START, ST_RSTART: begin
          a.send_valid = 1'b1;
          a.tx_byte    = {act_tgt, 1'b0};
        end
        ST_SLA_ACK: begin
          send_or_finish(a);
        end
        ST_DATA_ACK: begin
          if (LEN_W'(send_pos) < act_len)
            send_pos++;
          send_or_finish(a);
        end
        ST_SLA_NACK: begin
          if (!retries_exhausted(a, ERR_ADDR))
            a.issue_start = 1'b1;
        end
        ST_ARB_LOST: begin
          if (!retries_exhausted(a, ERR_ARB))
            a.issue_start = 1'b1;
        end
        ST_DATA_NACK: begin
          if (!retries_exhausted(a, ERR_DATA))
            send_or_finish(a);
        end
        default: begin
          finish_xfer(a, ERR_UNEXP, 1'b0);
        end
      endcase
    end
    return a;
  endfunction

  // result checker: each accepted result beat against the oldest expectation
  always @(posedge clk) begin : result_check
    bus_action_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_actions.size() == 0) begin
        report_mismatch($sformatf("beat %0d arrived with nothing expected", beat_no));
      end else begin
        want = pending_actions.pop_front();
        check_field("issue_start", 8'(issue_start), 8'(want.issue_start));
        check_field("issue_stop",  8'(issue_stop),  8'(want.issue_stop));
        check_field("send_valid",  8'(send_valid),  8'(want.send_valid));
        check_field("tx_byte",     tx_byte,         want.tx_byte);
        check_field("done_res",    8'(done_res),    8'(want.done_res));
        check_field("error_code",  8'(error_code),  8'(want.error_code));
      end
      beat_no++;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // request with every field random, so that unused fields toggle too
  function automatic item_t rand_item(input logic [1:0] kind);
    item_t it;
    it.req_type       = kind;
    it.byte_index     = 8'($urandom_range(0, 255));
    it.byte_value     = 8'($urandom_range(0, 255));
    it.target_address = 7'($urandom_range(0, 127));
    it.payload_length = 8'($urandom_range(0, 255));
    it.bus_status     = 8'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic item_t make_load(input logic [7:0] idx, input logic [7:0] val);
    item_t it;
    it            = rand_item(REQ_LOAD);
    it.byte_index = idx;
    it.byte_value = val;
    return it;
  endfunction

  function automatic item_t make_start(input logic [6:0] tgt, input logic [7:0] len);
    item_t it;
    it                = rand_item(REQ_START);
    it.target_address = tgt;
    it.payload_length = len;
    return it;
  endfunction

  // status code with random don't-care low bits
  function automatic item_t make_status(input logic [7:0] code);
    item_t it;
    it            = rand_item(REQ_STATUS);
    it.bus_status = code | 8'($urandom_range(0, 7));
    return it;
  endfunction

  // drive one request beat and wait for its acceptance; valid stays high on return
  task automatic send_req(input item_t it);
    if (sender_gaps && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    req_type       <= it.req_type;
    byte_index     <= it.byte_index;
    byte_value     <= it.byte_value;
    target_address <= it.target_address;
    payload_length <= it.payload_length;
    bus_status     <= it.bus_status;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_actions.push_back(step_sequencer(it));
  endtask

  // stop sending and let every outstanding result come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_actions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // retry limit is only touched with the block quiet
  task automatic write_retry_limit(input logic [7:0] val);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    retry_lim    = val;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // fill every buffer entry so no transfer ever reads an unwritten one
  task automatic load_full_buffer();
    for (int i = 0; i < BUF_DEPTH; i++)
      send_req(make_load(8'(i), 8'($urandom_range(0, 255))));
  endtask

  // hand-picked corners at the reset retry limit
  task automatic test_directed_sequence();
    // status while idle and unknown request type do nothing
    send_req(make_status(8'hFF));
    send_req(rand_item(REQ_UNUSED));
    // top address, empty payload, and a start while busy
    send_req(make_start(7'h7F, 8'd0));
    send_req(make_start(7'h00, 8'hFF));
    send_req(make_status(ST_START));
    send_req(make_status(ST_SLA_ACK));
    // two bytes, loads during the transfer, data nack resend
    send_req(make_start(7'h00, 8'd2));
    send_req(make_status(ST_RSTART));
    send_req(make_status(ST_SLA_ACK));
    send_req(make_load(8'd1, 8'h00));
    send_req(make_load(8'd0, 8'hFF));
    send_req(make_status(ST_DATA_NACK));
    send_req(make_status(ST_DATA_ACK));
    send_req(make_status(ST_DATA_ACK));
    // ack after done: block is idle again
    send_req(make_status(ST_DATA_ACK));
    // arbitration loss and address nack retry, then an unlisted code
    send_req(make_start(7'h55, 8'd1));
    send_req(make_status(ST_START));
    send_req(make_status(ST_ARB_LOST));
    send_req(make_status(ST_SLA_NACK));
    send_req(make_status(8'h00));
    // all-ones masked code is unexpected too
    send_req(make_start(7'h2A, 8'd1));
    send_req(make_status(ST_MASK));
    // top buffer index
    send_req(make_load(8'hFF, 8'h5A));
  endtask

  // retry limit zero: second failure of each kind stops the transfer
  task automatic test_retry_exhaustion();
    write_retry_limit(8'd0);
    send_req(make_start(7'($urandom_range(0, 127)), 8'd3));
    send_req(make_status(ST_START));
    send_req(make_status(ST_SLA_NACK));
    send_req(make_status(ST_SLA_NACK));
    send_req(make_start(7'($urandom_range(0, 127)), 8'd3));
    send_req(make_status(ST_START));
    send_req(make_status(ST_SLA_ACK));
    send_req(make_status(ST_DATA_NACK));
    send_req(make_status(ST_DATA_NACK));
    send_req(make_start(7'($urandom_range(0, 127)), 8'd3));
    send_req(make_status(ST_ARB_LOST));
    send_req(make_status(ST_ARB_LOST));
  endtask

  // retry limit 255: counter saturates and the transfer never gives up
  task automatic test_retry_saturation();
    write_retry_limit(8'hFF);
    send_req(make_start(7'($urandom_range(0, 127)), 8'd1));
    send_req(make_status(ST_START));
    for (int k = 0; k < 260; k++) begin
      case (k % 3)
        0:       send_req(make_status(ST_SLA_NACK));
        1:       send_req(make_status(ST_ARB_LOST));
        default: send_req(make_status(ST_DATA_NACK));
      endcase
    end
    send_req(make_status(ST_SLA_ACK));
    send_req(make_status(ST_DATA_ACK));
  endtask

  // mostly well-formed transfers with random content, plus noise
  task automatic test_random_traffic(input logic [7:0] limit, input int n_items,
                                     input logic idling);
    int    sent;
    int    r;
    int    r_len;
    item_t it;
    logic  ignored;
    write_retry_limit(limit);
    sender_gaps = idling;
    sink_stalls = idling;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      if (!xfer_busy) begin
        if (r < 65) begin
          it    = make_start(7'($urandom_range(0, 127)), 8'd0);
          r_len = $urandom_range(0, 99);
          // mostly short payloads, a few long ones
          if (r_len < 2)
            it.payload_length = 8'($urandom_range(64, 255));
          else if (r_len < 15)
            it.payload_length = 8'($urandom_range(7, 32));
          else
            it.payload_length = 8'($urandom_range(0, 6));
        end else if (r < 85) begin
          it = rand_item(REQ_LOAD);
        end else if (r < 95) begin
          it = rand_item(REQ_STATUS);
        end else begin
          it = rand_item(REQ_UNUSED);
        end
      end else begin
        if (r < 6)
          it = make_status(ST_START);
        else if (r < 12)
          it = make_status(ST_RSTART);
        else if (r < 24)
          it = make_status(ST_SLA_ACK);
        else if (r < 60)
          it = make_status(ST_DATA_ACK);
        else if (r < 68)
          it = make_status(ST_SLA_NACK);
        else if (r < 76)
          it = make_status(ST_DATA_NACK);
        else if (r < 82)
          it = make_status(ST_ARB_LOST);
        else if (r < 85)
          // codes outside the known set: zero, or 0x40 and up
          it = make_status($urandom_range(0, 1) ? 8'h00 : {5'($urandom_range(8, 31)), 3'b000});
        else if (r < 89)
          it = rand_item(REQ_START);
        else if (r < 96)
          it = rand_item(REQ_LOAD);
        else
          it = rand_item(REQ_UNUSED);
      end
      ignored = (it.req_type == REQ_UNUSED) || (it.req_type == REQ_STATUS && !xfer_busy);
      send_req(it);
      if (!ignored)
        sent++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence of tests
  // ---------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    load_full_buffer();
    test_directed_sequence();
    test_retry_exhaustion();
    test_retry_saturation();
    test_random_traffic(8'd1, 150, 1'b1);
    test_random_traffic(8'hFF, 150, 1'b1);
    test_random_traffic(8'($urandom_range(2, 254)), 150, 1'b1);
    test_random_traffic(8'd0, 150, 1'b1);
    test_random_traffic(RETRY_RESET, 150, 1'b1);
    // closing stretch with no idling on either side
    test_random_traffic(8'($urandom_range(0, 255)), 150, 1'b0);

    drain_results();
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
